[design/waveform_pulse_finder_top_defines.svh]
// ----------------------------------------------------------------------------
// waveform pulse finder assertion macros
// shared assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_PULSE_FINDER_TOP_DEFINES_SVH
`define WAVEFORM_PULSE_FINDER_TOP_DEFINES_SVH

// same-cycle implication
`define WPF_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("wpf assertion failed");

// next-cycle implication
`define WPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("wpf assertion failed");

`endif

[design/wpf_pkg.sv]
// ----------------------------------------------------------------------------
// wpf_pkg
// types and constants shared by the pulse finder modules
// ----------------------------------------------------------------------------
`default_nettype none

package wpf_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int INDEX_W   = 12;
	localparam int AREA_W    = 24;
	localparam int CFG_IDX_W = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL       = CFG_IDX_W'(1);

	// reset values
	localparam logic [SAMPLE_W-1:0] START_THRESHOLD_RST = '1;
	localparam logic [SAMPLE_W-1:0] END_LEVEL_RST       = '0;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic                last_in_buffer;
	} sample_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  start_index;
		logic [INDEX_W-1:0]  peak_index;
		logic [INDEX_W-1:0]  end_index;
		logic [AREA_W-1:0]   pulse_area;
		logic [SAMPLE_W-1:0] peak_value;
	} pulse_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] start_threshold;
		logic [SAMPLE_W-1:0] end_level;
	} cfg_t;

endpackage

`default_nettype wire

[design/wpf_core.sv]
// ----------------------------------------------------------------------------
// wpf_core
// pulse tracking state: open/close decision, running area, peak search
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_pulse_finder_top_defines.svh"

module wpf_core #(
	parameter int MAX_SAMPLES = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire wpf_pkg::sample_t item,
	input  wire wpf_pkg::cfg_t   cfg,
	output logic                 res_valid,
	output wpf_pkg::pulse_t      res
);

	localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

	logic                          inside_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              start_q;
	logic [CNT_W-1:0]              best_idx_q;
	logic [wpf_pkg::SAMPLE_W-1:0]  best_val_q;
	logic [wpf_pkg::AREA_W-1:0]    area_q;

	logic                          opens;
	logic                          closes;
	logic                          new_best;
	logic [wpf_pkg::AREA_W-1:0]    area_base;
	logic [wpf_pkg::AREA_W:0]      area_sum;
	logic [wpf_pkg::AREA_W-1:0]    area_sat;

	assign opens    = !inside_q && (item.sample_value > cfg.start_threshold);
	assign new_best = item.sample_value > best_val_q;
	assign closes   = inside_q &&
		((item.sample_value < cfg.end_level) || item.last_in_buffer);

	// fresh pulse restarts the sum from zero
	assign area_base = opens ? '0 : area_q;
	assign area_sum  = {1'b0, area_base} + (wpf_pkg::AREA_W + 1)'(item.sample_value);
	assign area_sat  = area_sum[wpf_pkg::AREA_W] ? '1 : area_sum[wpf_pkg::AREA_W-1:0];

	assign res_valid        = step && closes;
	assign res.start_index  = wpf_pkg::INDEX_W'(start_q);
	assign res.peak_index   = new_best ? wpf_pkg::INDEX_W'(cnt_q) : wpf_pkg::INDEX_W'(best_idx_q);
	assign res.end_index    = wpf_pkg::INDEX_W'(cnt_q);
	assign res.pulse_area   = area_sat;
	assign res.peak_value   = new_best ? item.sample_value : best_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			cnt_q      <= '0;
			start_q    <= '0;
			best_idx_q <= '0;
			best_val_q <= '0;
			area_q     <= '0;
		end else if (step) begin
			if (opens) begin
				start_q    <= cnt_q;
				best_idx_q <= cnt_q;
				best_val_q <= item.sample_value;
				area_q     <= area_sat;
			end else if (inside_q) begin
				area_q <= area_sat;
				if (new_best) begin
					best_idx_q <= cnt_q;
					best_val_q <= item.sample_value;
				end
			end

			if (item.last_in_buffer) begin
				inside_q <= 1'b0;
			end else if (opens) begin
				inside_q <= 1'b1;
			end else if (closes) begin
				inside_q <= 1'b0;
			end

			if (item.last_in_buffer || (cnt_q >= CNT_LAST)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	`WPF_ASSERT_IMPLIES(a_result_needs_pulse, res_valid, inside_q)
	`WPF_ASSERT_NEXT(a_buffer_end_clears, (step && item.last_in_buffer), (!inside_q && cnt_q == '0))

endmodule

`default_nettype wire

[design/waveform_pulse_finder_top.sv]
// ----------------------------------------------------------------------------
// waveform_pulse_finder_top
// threshold pulse finder reporting start, peak and end index, area and peak
// ----------------------------------------------------------------------------
// usage
//   sample channel: one ADC sample per beat (sample_valid / sample_stall),
//     last_in_buffer marks the final sample of a buffer, index restarts after it
//   pulse channel: one beat per closed pulse (pulse_valid / pulse_stall)
//   cfg channel: index/data writes, always ready; write only while idle
//   latency: a sample taken at edge N is processed at edge N+1, so the pulse
//     it closes is offered right after N+1 and can be taken at edge N+2
//   throughput: one sample per cycle, set by the single-pass state update
//     between the input register and the result register
//   stall: results queue in an output register plus one skid register; once
//     the skid register is full the input register holds and sample_stall rises
//   reset: thresholds return to start 4095 / end 0, no pulse open, index 0,
//     all buffered beats dropped
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_pulse_finder_top_defines.svh"

module waveform_pulse_finder_top #(
	parameter int MAX_SAMPLES = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// sample channel
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire wpf_pkg::sample_t                  sample,
	// pulse channel
	output logic                                   pulse_valid,
	input  wire logic                              pulse_stall,
	output wpf_pkg::pulse_t                        pulse,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [wpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wpf_pkg::SAMPLE_W-1:0]      cfg_data
);

	// configuration registers
	wpf_pkg::cfg_t      cfg_q;

	// input register
	logic               s1_valid_q;
	wpf_pkg::sample_t   sample_s1;

	// result register and skid register
	logic               out_valid_q;
	logic               skid_valid_q;
	wpf_pkg::pulse_t    out_q;
	wpf_pkg::pulse_t    skid_q;

	logic               accept;
	logic               step;
	logic               pop;
	logic               res_valid;
	wpf_pkg::pulse_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_threshold <= wpf_pkg::START_THRESHOLD_RST;
			cfg_q.end_level       <= wpf_pkg::END_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wpf_pkg::REG_START_THRESHOLD: cfg_q.start_threshold <= cfg_data;
				wpf_pkg::REG_END_LEVEL:       cfg_q.end_level       <= cfg_data;
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// the input register only moves on when the skid register has room,
	// so a result produced by this step always has a place to land
	assign step         = s1_valid_q && !skid_valid_q;
	assign sample_stall = s1_valid_q && skid_valid_q;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (step) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	wpf_core #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (sample_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// output side: the result register is the oldest beat, skid the next one
	assign pop         = out_valid_q && !pulse_stall;
	assign pulse_valid = out_valid_q;
	assign pulse       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= res_valid;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (res_valid) begin
					skid_q <= res;
				end
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	`WPF_ASSERT_IMPLIES(a_skid_needs_out, skid_valid_q, out_valid_q)
	`WPF_ASSERT_IMPLIES(a_no_push_when_full, res_valid, (step && !skid_valid_q))
	`WPF_ASSERT_NEXT(a_stall_keeps_s1, (s1_valid_q && skid_valid_q), s1_valid_q)

endmodule

`default_nettype wire
